/* rtl/camera_point_projection_assert.svh */
// Assertion macros shared by the camera point projection modules.
`ifndef CAMERA_POINT_PROJECTION_ASSERT_SVH
`define CAMERA_POINT_PROJECTION_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CPP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cpp_pkg.sv */
// Types and constants shared by the camera point projection modules.
package cpp_pkg;

    localparam int W_COEF    = 16;
    localparam int W_PT      = 32;
    localparam int W_PROD    = 48;
    localparam int W_ACC     = 50;
    localparam int ROW_SHIFT = 8;
    localparam int W_ROW     = W_ACC - ROW_SHIFT;
    localparam int T_SHIFT   = 24;
    localparam int FRAC      = 16;
    localparam int DIV_STEPS = 33;
    localparam int SAT_SHIFT = DIV_STEPS - FRAC;
    localparam int W_FIN     = 44;
    localparam int W_PIX     = 16;
    localparam int W_CFG_IDX = 3;
    localparam int W_CFG     = 64;

    typedef enum logic [W_CFG_IDX-1:0] {
        CFG_ROW_X     = 3'd0,
        CFG_ROW_Y     = 3'd1,
        CFG_ROW_Z     = 3'd2,
        CFG_CENTRE_X  = 3'd3,
        CFG_CENTRE_Y  = 3'd4,
        CFG_FLIP_BASE = 3'd5,
        CFG_PARALLEL  = 3'd6,
        CFG_FLIP_V    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [W_COEF-1:0] t;
        logic signed [W_COEF-1:0] c;
        logic signed [W_COEF-1:0] b;
        logic signed [W_COEF-1:0] a;
    } t_row;

    typedef struct packed {
        logic signed [W_PT-1:0] point_x;
        logic signed [W_PT-1:0] point_y;
        logic signed [W_PT-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic signed [31:0]      image_x;
        logic signed [31:0]      image_y;
        logic signed [31:0]      depth;
        logic signed [W_PIX-1:0] pixel_x;
        logic signed [W_PIX-1:0] pixel_y;
        logic                    in_front;
    } t_result;

    typedef struct packed {
        logic signed [W_ROW-1:0] x;
        logic signed [W_ROW-1:0] y;
        logic signed [W_ROW-1:0] z;
        logic [W_ROW-1:0]        ax;
        logic [W_ROW-1:0]        ay;
        logic                    persp;
        logic                    bigx;
        logic                    bigy;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

/* rtl/camera_point_projection.sv */
// Camera point projection: one point in, one projected result out, every clock cycle unless stalled.
// Each accepted point is multiplied by the configured 3x4 camera matrix; in perspective mode with a
// positive depth it is divided by that depth and offset by the image centre. It is then optionally
// flipped and saturated. The block takes one point and delivers one result per clock while the queue
// has room and the receiver is ready. The path runs through the two multiply and sum stages, the
// queue, the 33-stage restoring divider (one quotient bit per stage) and the two final stages. A
// four-word queue separates the matrix front end from the divider, so each side may stall on its own.
// Configuration uses a plain write port, written by the user while no point is in flight (unenforced).
module camera_point_projection #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cpp_pkg::W_CFG_IDX-1:0]   i_cfg_index,
    input  logic [cpp_pkg::W_CFG-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  cpp_pkg::t_point                 i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output cpp_pkg::t_result                o_out_data
);
    cpp_pkg::t_row      r_row_x;
    cpp_pkg::t_row      r_row_y;
    cpp_pkg::t_row      r_row_z;
    logic signed [31:0] r_centre_x;
    logic signed [31:0] r_centre_y;
    logic signed [31:0] r_flip_base;
    logic               r_parallel;
    logic               r_flip;

    logic               w_push;
    logic               w_pop;
    cpp_pkg::t_entry    w_entry;
    cpp_pkg::t_entry    w_head;
    cpp_pkg::t_qstat    w_qstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x     <= '0;
            r_row_y     <= '0;
            r_row_z     <= '0;
            r_centre_x  <= '0;
            r_centre_y  <= '0;
            r_flip_base <= '0;
            r_parallel  <= 1'b0;
            r_flip      <= 1'b0;
        end else if (i_cfg_we) begin
            case (cpp_pkg::t_cfg_idx'(i_cfg_index))
                cpp_pkg::CFG_ROW_X:     r_row_x     <= cpp_pkg::t_row'(i_cfg_data);
                cpp_pkg::CFG_ROW_Y:     r_row_y     <= cpp_pkg::t_row'(i_cfg_data);
                cpp_pkg::CFG_ROW_Z:     r_row_z     <= cpp_pkg::t_row'(i_cfg_data);
                cpp_pkg::CFG_CENTRE_X:  r_centre_x  <= i_cfg_data[31:0];
                cpp_pkg::CFG_CENTRE_Y:  r_centre_y  <= i_cfg_data[31:0];
                cpp_pkg::CFG_FLIP_BASE: r_flip_base <= i_cfg_data[31:0];
                cpp_pkg::CFG_PARALLEL:  r_parallel  <= i_cfg_data[0];
                cpp_pkg::CFG_FLIP_V:    r_flip      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    cpp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_data     (i_in_data),
        .i_row_x    (r_row_x),
        .i_row_y    (r_row_y),
        .i_row_z    (r_row_z),
        .i_parallel (r_parallel),
        .i_qstat    (w_qstat),
        .o_push     (w_push),
        .o_entry    (w_entry)
    );

    cpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    cpp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_qstat     (w_qstat),
        .o_pop       (w_pop),
        .i_centre_x  (r_centre_x),
        .i_centre_y  (r_centre_y),
        .i_flip_base (r_flip_base),
        .i_flip      (r_flip),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (o_out_data)
    );

endmodule

/* rtl/cpp_front.sv */
// Front end: row products, row sums and classification of each point.
module cpp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cpp_pkg::t_point i_data,
    input  cpp_pkg::t_row   i_row_x,
    input  cpp_pkg::t_row   i_row_y,
    input  cpp_pkg::t_row   i_row_z,
    input  logic            i_parallel,
    input  cpp_pkg::t_qstat i_qstat,
    output logic            o_push,
    output cpp_pkg::t_entry o_entry
);
    localparam int WP = cpp_pkg::W_PROD;
    localparam int WA = cpp_pkg::W_ACC;
    localparam int WR = cpp_pkg::W_ROW;
    localparam int WC = cpp_pkg::W_COEF;
    localparam int SS = cpp_pkg::SAT_SHIFT;

    logic                 w_en;
    cpp_pkg::t_row        w_rows [3];
    logic signed [WC-1:0] w_coef [3][3];
    logic signed [31:0]   w_pt   [3];
    logic signed [WA-1:0] w_acc  [3];

    logic                 r_v1;
    logic                 r_v2;
    logic signed [WP-1:0] r_prod [3][3];
    logic signed [WC-1:0] r_t    [3];
    logic signed [WR-1:0] r_row  [3];

    assign w_en    = !i_qstat.full;
    assign o_ready = w_en;
    assign o_push  = w_en && r_v2;

    always_comb begin
        w_rows[0] = i_row_x;
        w_rows[1] = i_row_y;
        w_rows[2] = i_row_z;
        w_pt[0]   = i_data.point_x;
        w_pt[1]   = i_data.point_y;
        w_pt[2]   = i_data.point_z;
        for (int k = 0; k < 3; k++) begin
            w_coef[k][0] = w_rows[k].a;
            w_coef[k][1] = w_rows[k].b;
            w_coef[k][2] = w_rows[k].c;
            w_acc[k] = WA'(r_prod[k][0]) + WA'(r_prod[k][1]) + WA'(r_prod[k][2])
                     + (WA'(r_t[k]) <<< cpp_pkg::T_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[k][j] <= WP'(w_coef[k][j]) * WP'(w_pt[j]);
                end
                r_t[k]   <= w_rows[k].t;
                // Arithmetic shift of the Q.24 sum gives the floored Q26.16 value.
                r_row[k] <= w_acc[k][WA-1:cpp_pkg::ROW_SHIFT];
            end
        end
    end

    // A quotient of 2^33 or more saturates whatever centre is added, so such
    // points are flagged here and the divider only forms 33 quotient bits.
    always_comb begin
        o_entry.x     = r_row[0];
        o_entry.y     = r_row[1];
        o_entry.z     = r_row[2];
        o_entry.ax    = r_row[0][WR-1] ? unsigned'(-r_row[0]) : unsigned'(r_row[0]);
        o_entry.ay    = r_row[1][WR-1] ? unsigned'(-r_row[1]) : unsigned'(r_row[1]);
        o_entry.persp = !i_parallel && !r_row[2][WR-1] && (r_row[2] != '0);
        o_entry.bigx  = {{SS{1'b0}}, o_entry.ax} >= {unsigned'(r_row[2]), {SS{1'b0}}};
        o_entry.bigy  = {{SS{1'b0}}, o_entry.ay} >= {unsigned'(r_row[2]), {SS{1'b0}}};
    end

endmodule

/* rtl/cpp_queue.sv */
// Short word queue between the front end and the divider back end.
`include "camera_point_projection_assert.svh"

module cpp_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cpp_pkg::t_entry i_entry,
    input  logic            i_pop,
    output cpp_pkg::t_entry o_head,
    output cpp_pkg::t_qstat o_qstat
);
    localparam int W_PTR = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int W_CNT = $clog2(DEPTH + 1);

    cpp_pkg::t_entry  r_mem [DEPTH];
    logic [W_PTR-1:0] r_wr;
    logic [W_PTR-1:0] r_rd;
    logic [W_CNT-1:0] r_cnt;
    logic [W_PTR-1:0] n_wr;
    logic [W_PTR-1:0] n_rd;
    logic [W_CNT-1:0] n_cnt;

    assign o_head        = r_mem[r_rd];
    assign o_qstat.full  = (r_cnt == W_CNT'(DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == W_PTR'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == W_PTR'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    `CPP_ASSERT_IMPL(a_push_not_full, i_clk, i_rst_n, i_push, !o_qstat.full, "push into full queue")
    `CPP_ASSERT_IMPL(a_pop_not_empty, i_clk, i_rst_n, i_pop, !o_qstat.empty, "pop from empty queue")
    `CPP_ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, i_push && !i_pop, r_cnt == $past(r_cnt) + 1'b1, "queue count lost a push")

endmodule

/* rtl/cpp_back.sv */
// Back end: pipelined restoring divider, centre, flip, saturation and output register.
`include "camera_point_projection_assert.svh"

module cpp_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  cpp_pkg::t_entry         i_head,
    input  cpp_pkg::t_qstat         i_qstat,
    output logic                    o_pop,
    input  logic signed [31:0]      i_centre_x,
    input  logic signed [31:0]      i_centre_y,
    input  logic signed [31:0]      i_flip_base,
    input  logic                    i_flip,
    output logic                    o_valid,
    input  logic                    i_ready,
    output cpp_pkg::t_result        o_data
);
    localparam int WR = cpp_pkg::W_ROW;
    localparam int ND = cpp_pkg::DIV_STEPS;
    localparam int WF = cpp_pkg::W_FIN;
    localparam int WQ = ND + 1;
    localparam int SS = cpp_pkg::SAT_SHIFT;
    localparam int FR = cpp_pkg::FRAC;
    localparam int WS = 34;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [WS-1:0] HALF    = WS'(32768);
    localparam logic signed [WS-1:0] ROUND_N = WS'(65535);
    localparam logic signed [WS-FR-1:0] PIX_MAX = (WS-FR)'(32767);

    typedef struct packed {
        logic signed [WR-1:0] x;
        logic signed [WR-1:0] y;
        logic signed [WR-1:0] z;
        logic                 persp;
        logic                 bigx;
        logic                 bigy;
        logic [WR-1:0]        rx;
        logic [WR-1:0]        ry;
        logic [ND-1:0]        dx;
        logic [ND-1:0]        dy;
    } t_dstage;

    typedef struct packed {
        logic signed [WF-1:0] x;
        logic signed [WF-1:0] y;
        logic signed [WR-1:0] z;
        logic                 front;
    } t_fin;

    function automatic logic [WR+ND-1:0] f_step(input logic [WR-1:0] r,
                                                input logic [ND-1:0] d,
                                                input logic [WR-1:0] z);
        logic [WR:0] t;
        logic [WR:0] diff;
        t    = {r, d[ND-1]};
        diff = t - {1'b0, z};
        if (t >= {1'b0, z}) begin
            return {diff[WR-1:0], d[ND-2:0], 1'b1};
        end
        return {t[WR-1:0], d[ND-2:0], 1'b0};
    endfunction

    function automatic t_dstage f_stage(input t_dstage s);
        t_dstage n;
        n = s;
        {n.rx, n.dx} = f_step(s.rx, s.dx, unsigned'(s.z));
        {n.ry, n.dy} = f_step(s.ry, s.dy, unsigned'(s.z));
        return n;
    endfunction

    function automatic logic signed [WF-1:0] f_quot(input logic big, input logic neg,
                                                    input logic [ND-1:0] d);
        logic [WQ-1:0]        q;
        logic signed [WF-1:0] v;
        q = big ? {1'b1, {ND{1'b0}}} : {1'b0, d};
        v = WF'(q);
        return neg ? -v : v;
    endfunction

    function automatic logic signed [31:0] f_sat(input logic signed [WF-1:0] v);
        if (v > WF'(S32_MAX)) begin
            return S32_MAX;
        end
        if (v < WF'(S32_MIN)) begin
            return S32_MIN;
        end
        return v[31:0];
    endfunction

    // Add one half, then shift with rounding toward zero.
    function automatic logic signed [cpp_pkg::W_PIX-1:0] f_pix(input logic signed [31:0] img);
        logic signed [WS-1:0]    s;
        logic signed [WS-FR-1:0] p;
        s = WS'(img) + HALF;
        if (s[WS-1]) begin
            s = s + ROUND_N;
        end
        p = s[WS-1:FR];
        if (p > PIX_MAX) begin
            return PIX_MAX[cpp_pkg::W_PIX-1:0];
        end
        return p[cpp_pkg::W_PIX-1:0];
    endfunction

    logic    w_en;
    t_dstage w_head;
    t_dstage w_in [ND];
    t_dstage w_nx [ND];
    t_fin    w_fin;
    logic signed [WF-1:0] w_y;

    t_dstage          r_ds [ND];
    logic             r_dv [ND];
    t_fin             r_a;
    logic             r_av;
    cpp_pkg::t_result r_out;
    logic             r_ov;

    assign w_en    = !r_ov || i_ready;
    assign o_pop   = w_en && !i_qstat.empty;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_comb begin
        w_head.x     = i_head.x;
        w_head.y     = i_head.y;
        w_head.z     = i_head.z;
        w_head.persp = i_head.persp;
        w_head.bigx  = i_head.bigx;
        w_head.bigy  = i_head.bigy;
        w_head.rx    = i_head.ax >> SS;
        w_head.ry    = i_head.ay >> SS;
        w_head.dx    = {i_head.ax[SS-1:0], {FR{1'b0}}};
        w_head.dy    = {i_head.ay[SS-1:0], {FR{1'b0}}};
    end

    for (genvar s = 0; s < ND; s++) begin : g_div
        if (s == 0) begin : g_first
            assign w_in[s] = w_head;
        end else begin : g_rest
            assign w_in[s] = r_ds[s-1];
        end
        assign w_nx[s] = f_stage(w_in[s]);
    end

    always_comb begin
        w_fin.z     = r_ds[ND-1].z;
        w_fin.front = r_ds[ND-1].persp;
        if (r_ds[ND-1].persp) begin
            w_fin.x = f_quot(r_ds[ND-1].bigx, r_ds[ND-1].x[WR-1], r_ds[ND-1].dx)
                    + WF'(i_centre_x);
            w_y     = f_quot(r_ds[ND-1].bigy, r_ds[ND-1].y[WR-1], r_ds[ND-1].dy)
                    + WF'(i_centre_y);
        end else begin
            w_fin.x = WF'(r_ds[ND-1].x);
            w_y     = WF'(r_ds[ND-1].y);
        end
        w_fin.y = i_flip ? WF'(i_flip_base) - w_y : w_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < ND; s++) begin
                r_dv[s] <= 1'b0;
            end
            r_av <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_dv[0] <= o_pop;
            for (int s = 1; s < ND; s++) begin
                r_dv[s] <= r_dv[s-1];
            end
            r_av <= r_dv[ND-1];
            r_ov <= r_av;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < ND; s++) begin
                r_ds[s] <= w_nx[s];
            end
            r_a               <= w_fin;
            r_out.image_x     <= f_sat(r_a.x);
            r_out.image_y     <= f_sat(r_a.y);
            r_out.depth       <= f_sat(WF'(r_a.z));
            r_out.pixel_x     <= f_pix(f_sat(r_a.x));
            r_out.pixel_y     <= f_pix(f_sat(r_a.y));
            r_out.in_front    <= r_a.front;
        end
    end

    `CPP_ASSERT_IMPL(a_front_depth, i_clk, i_rst_n, r_ov && r_out.in_front, r_out.depth > 32'sd0, "division applied with depth not positive")
    `CPP_ASSERT_IMPL(a_pix_top, i_clk, i_rst_n, r_ov && (r_out.pixel_x == 16'sd32767), r_out.image_x >= 32'sd2147385344, "pixel x saturated too early")
    `CPP_ASSERT_NEXT(a_div_to_fin, i_clk, i_rst_n, w_en && r_dv[ND-1], r_av, "divider word lost before final stage")

endmodule

/* tb/sv/camera_point_projection_tb.sv */
// Self-checking testbench for the camera point projection block.
module camera_point_projection_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [cpp_pkg::W_CFG_IDX-1:0] i_cfg_index = '0;
    logic [cpp_pkg::W_CFG-1:0]     i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    cpp_pkg::t_point               i_in_data = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    cpp_pkg::t_result              o_out_data;

    camera_point_projection uut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow copy of the camera configuration.
    logic [63:0]        m_row [3];
    logic signed [63:0] m_cx, m_cy, m_fb;
    logic               m_par, m_flip;

    cpp_pkg::t_result projected_q [$];
    int      n_fail = 0;
    bit      rx_stall_on = 1'b1;

    typedef struct {
        cpp_pkg::t_point  pt;
        bit               has_res;
        cpp_pkg::t_result res;
    } t_vec;

    function automatic logic signed [63:0] row_eval(logic [63:0] row, cpp_pkg::t_point p);
        logic signed [63:0] acc;
        acc = 64'(signed'(row[15:0])) * 64'(p.point_x)
            + 64'(signed'(row[31:16])) * 64'(p.point_y)
            + 64'(signed'(row[47:32])) * 64'(p.point_z)
            + (64'(signed'(row[63:48])) <<< 24);
        return acc >>> 8;
    endfunction

    function automatic logic signed [63:0] clip(logic signed [63:0] v,
                                                logic signed [63:0] lo,
                                                logic signed [63:0] hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic signed [15:0] pixel_of(logic signed [63:0] img);
        logic signed [63:0] s;
        s = img + 64'sd32768;
        // Division truncates toward zero, as the rounding requires.
        return 16'(clip(s / 64'sd65536, -64'sd32768, 64'sd32767));
    endfunction

    function automatic cpp_pkg::t_result project(cpp_pkg::t_point p);
        cpp_pkg::t_result r;
        logic signed [63:0] x, y, z, ix, iy;
        logic front;
        x = row_eval(m_row[0], p);
        y = row_eval(m_row[1], p);
        z = row_eval(m_row[2], p);
        front = 1'b0;
        if (!m_par && z > 0) begin
            x = (x * 64'sd65536) / z + m_cx;
            y = (y * 64'sd65536) / z + m_cy;
            front = 1'b1;
        end
        if (m_flip) y = m_fb - y;
        ix = clip(x, -64'sd2147483648, 64'sd2147483647);
        iy = clip(y, -64'sd2147483648, 64'sd2147483647);
        r.image_x  = 32'(ix);
        r.image_y  = 32'(iy);
        r.depth    = 32'(clip(z, -64'sd2147483648, 64'sd2147483647));
        r.pixel_x  = pixel_of(ix);
        r.pixel_y  = pixel_of(iy);
        r.in_front = front;
        return r;
    endfunction

    task automatic cfg_write(cpp_pkg::t_cfg_idx idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            cpp_pkg::CFG_ROW_X:     m_row[0] = val;
            cpp_pkg::CFG_ROW_Y:     m_row[1] = val;
            cpp_pkg::CFG_ROW_Z:     m_row[2] = val;
            cpp_pkg::CFG_CENTRE_X:  m_cx = 64'(signed'(val[31:0]));
            cpp_pkg::CFG_CENTRE_Y:  m_cy = 64'(signed'(val[31:0]));
            cpp_pkg::CFG_FLIP_BASE: m_fb = 64'(signed'(val[31:0]));
            cpp_pkg::CFG_PARALLEL:  m_par = val[0];
            cpp_pkg::CFG_FLIP_V:    m_flip = val[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (projected_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
    endtask

    // Send one word; valid stays high across back-to-back words, and valid drops after
    // a word that ends a burst.
    task automatic send_point(cpp_pkg::t_point p, bit hold);
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        projected_q.push_back(project(p));
        if (!hold) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic logic [63:0] rand_row(bit full_range);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if (!full_range) begin
            // Modest coefficients keep most points on the image.
            r[15:0]  = 16'($signed($urandom_range(0, 1024)) - 512);
            r[31:16] = 16'($signed($urandom_range(0, 1024)) - 512);
            r[47:32] = 16'($signed($urandom_range(0, 1024)) - 512);
            r[63:48] = 16'($signed($urandom_range(0, 200)) - 100);
        end
        return r;
    endfunction

    function automatic cpp_pkg::t_point rand_point();
        cpp_pkg::t_point p;
        case ($urandom_range(0, 3))
            0: p = {$urandom, $urandom, $urandom};
            default: begin
                p.point_x = 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
                p.point_y = 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
                p.point_z = 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0020_0000);
            end
        endcase
        return p;
    endfunction

    // Receiver stall pattern, switched off for some stretches.
    always @(posedge i_clk) begin
        if (!rx_stall_on) i_out_ready <= 1'b1;
        else i_out_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        cpp_pkg::t_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (projected_q.size() == 0) begin
                $error("unexpected result word");
                n_fail++;
            end else begin
                e = projected_q.pop_front();
                if (o_out_data.image_x !== e.image_x) begin
                    $error("image_x exp %0d got %0d", e.image_x, o_out_data.image_x); n_fail++;
                end
                if (o_out_data.image_y !== e.image_y) begin
                    $error("image_y exp %0d got %0d", e.image_y, o_out_data.image_y); n_fail++;
                end
                if (o_out_data.depth !== e.depth) begin
                    $error("depth exp %0d got %0d", e.depth, o_out_data.depth); n_fail++;
                end
                if (o_out_data.pixel_x !== e.pixel_x) begin
                    $error("pixel_x exp %0d got %0d", e.pixel_x, o_out_data.pixel_x); n_fail++;
                end
                if (o_out_data.pixel_y !== e.pixel_y) begin
                    $error("pixel_y exp %0d got %0d", e.pixel_y, o_out_data.pixel_y); n_fail++;
                end
                if (o_out_data.in_front !== e.in_front) begin
                    $error("in_front exp %0d got %0d", e.in_front, o_out_data.in_front);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("camera_point_projection_tb NOT OK");
        $finish;
    end

    initial begin
        t_vec             vecs [$];
        cpp_pkg::t_result r0;
        int               burst, phase, k;
        m_row[0] = '0; m_row[1] = '0; m_row[2] = '0;
        m_cx = 0; m_cy = 0; m_fb = 0; m_par = 0; m_flip = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset the matrix is zero: every point maps to zero, depth not positive.
        r0 = '0;
        vecs.push_back('{'{32'sh7fffffff, 32'sh80000000, 32'sh12345678}, 1'b1, r0});
        vecs.push_back('{'{32'sh80000000, 32'sh7fffffff, 32'sh80000000}, 1'b1, r0});
        foreach (vecs[i]) begin
            send_point(vecs[i].pt, 1'b0);
            if (vecs[i].has_res && projected_q[$] !== vecs[i].res) begin
                $error("reset result mismatch exp %h got %h", vecs[i].res, projected_q[$]);
                n_fail++;
            end
        end
        drain();

        // Identity-like camera with unit depth row plus translation 1.
        cfg_write(cpp_pkg::CFG_ROW_X, {16'sd0, 16'sd0, 16'sd0, 16'sh0100});
        cfg_write(cpp_pkg::CFG_ROW_Y, {16'sd0, 16'sd0, 16'sh0100, 16'sd0});
        cfg_write(cpp_pkg::CFG_ROW_Z, {16'sd1, 16'sh0100, 16'sd0, 16'sd0});
        cfg_write(cpp_pkg::CFG_CENTRE_X, 64'(32'sh0140_0000));
        cfg_write(cpp_pkg::CFG_CENTRE_Y, 64'(32'sh00f0_0000));
        cfg_write(cpp_pkg::CFG_FLIP_BASE, 64'(32'sh01e0_0000));
        vecs.delete();
        vecs.push_back('{'{32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000}, 1'b0, r0});
        vecs.push_back('{'{32'sh7fffffff, 32'sh80000000, 32'sh0000_0001}, 1'b0, r0});
        vecs.push_back('{'{32'sh0, 32'sh0, 32'shffff_0000}, 1'b0, r0}); // depth exactly zero
        vecs.push_back('{'{32'sh0, 32'sh0, 32'sh8000_0000}, 1'b0, r0}); // depth negative
        vecs.push_back('{'{32'sh7fffffff, 32'sh7fffffff, 32'shffff_0001}, 1'b0, r0});
        vecs.push_back('{'{32'sh8000_0000, 32'sh8000_0000, 32'sh7fffffff}, 1'b0, r0});
        foreach (vecs[i]) send_point(vecs[i].pt, i != vecs.size() - 1);
        drain();
        cfg_write(cpp_pkg::CFG_FLIP_V, 64'd1);
        foreach (vecs[i]) send_point(vecs[i].pt, 1'b0);
        drain();
        cfg_write(cpp_pkg::CFG_PARALLEL, 64'd1);
        foreach (vecs[i]) send_point(vecs[i].pt, 1'b0);
        drain();
        // Extreme coefficients exercise saturation of the outputs.
        cfg_write(cpp_pkg::CFG_ROW_X, {16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        cfg_write(cpp_pkg::CFG_ROW_Y, {16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        cfg_write(cpp_pkg::CFG_ROW_Z, {16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
        cfg_write(cpp_pkg::CFG_FLIP_BASE, 64'(32'sh7fffffff));
        foreach (vecs[i]) send_point(vecs[i].pt, 1'b0);
        drain();
        cfg_write(cpp_pkg::CFG_PARALLEL, 64'd0);
        foreach (vecs[i]) send_point(vecs[i].pt, 1'b0);
        drain();

        // Random phases, each with its own camera setting.
        for (phase = 0; phase < 8; phase++) begin
            cfg_write(cpp_pkg::CFG_ROW_X, rand_row(phase == 3));
            cfg_write(cpp_pkg::CFG_ROW_Y, rand_row(phase == 3));
            cfg_write(cpp_pkg::CFG_ROW_Z, rand_row(phase == 5));
            cfg_write(cpp_pkg::CFG_CENTRE_X, {$urandom, $urandom});
            cfg_write(cpp_pkg::CFG_CENTRE_Y, {$urandom, $urandom});
            cfg_write(cpp_pkg::CFG_FLIP_BASE,
                      phase == 6 ? 64'(32'sh80000000) : {$urandom, $urandom});
            cfg_write(cpp_pkg::CFG_PARALLEL, 64'(phase % 4 == 2));
            cfg_write(cpp_pkg::CFG_FLIP_V, 64'(phase[0]));
            rx_stall_on = (phase != 4);
            k = 0;
            while (k < 85) begin
                burst = $urandom_range(1, 12);
                for (int j = 0; j < burst && k < 85; j++, k++)
                    send_point(rand_point(), j != burst - 1 && k != 84);
                if (phase != 4) repeat ($urandom_range(0, 6)) @(posedge i_clk);
            end
            drain();
        end

        if (n_fail == 0 && projected_q.size() == 0)
            $display("camera_point_projection_tb OK");
        else
            $display("camera_point_projection_tb NOT OK");
        $finish;
    end
endmodule
